>>> hdl/assert_macros.svh
// Assertion macros for the keyed record table RTL.
// Relies on clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition holds at every edge out of reset
`define KRT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("keyed_record_table: invariant violated");

// check an implication in the same cycle
`define KRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed_record_table: implication violated");

// check an implication in the next cycle
`define KRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_record_table: next-cycle implication violated");

`endif

>>> hdl/krt_pkg.sv
// Types and constants shared by the keyed record table modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

  localparam logic [13:0] KEY_MAX   = 14'd10000;
  localparam logic [23:0] PRICE_MAX = 24'd10000000;
  localparam logic [19:0] QTY_MAX   = 20'd1000000;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_DELETE = 3'd3,
    OP_RANGE  = 3'd4,
    OP_LIST   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUP       = 3'd2,
    ST_KEY       = 3'd3,
    ST_PRICE     = 3'd4,
    ST_QTY       = 3'd5,
    ST_FULL      = 3'd6,
    ST_NOMATCH   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic [13:0] key;
    logic [23:0] price;
    logic [19:0] qty;
  } record_t;

  typedef struct packed {
    logic shift;
    logic compact;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/krt_cell.sv
// One record cell of the table ring.
// Depends on krt_pkg for the record and control types.
`timescale 1ns / 1ps
`default_nettype none

module krt_cell #(
  parameter int CAPACITY = 64,
  parameter int POS      = 0
) (
  input  wire logic                 clk,
  input  krt_pkg::cell_ctl_t        ctl,
  input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] del_idx,
  input  krt_pkg::record_t          nbr_in,
  output krt_pkg::record_t          rec_out
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  krt_pkg::record_t rec_r;
  logic             take;

  assign take    = ctl.shift || (ctl.compact && (IW'(POS) >= del_idx));
  assign rec_out = rec_r;

  always_ff @(posedge clk) begin
    if (take) begin
      rec_r <= nbr_in;
    end
  end

endmodule

`default_nettype wire

>>> hdl/keyed_record_table.sv
// Keyed record table: a ring of record cells rotated once per operation.
// Depends on krt_pkg, krt_cell and assert_macros.svh.
// After start, the cells rotate in the scan state, then the finish state registers the final result;
// busy covers both states, and a new operation is accepted only once one full rotation of the cell ring is done.
// Range and list results stream during the rotation, at most one per cycle; the last one comes with the final result.
// Reset clears the entry count and control; record cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module keyed_record_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [13:0] in_key_id,
  input  wire logic [23:0] in_price_cents,
  input  wire logic [19:0] in_new_quantity,
  input  wire logic [23:0] in_min_price_cents,
  input  wire logic [23:0] in_max_price_cents,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [13:0]      out_found_id,
  output logic [23:0]      out_found_price,
  output logic [19:0]      out_found_quantity,
  output logic             out_last_result
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  krt_pkg::state_t    state_r, state_nxt;
  krt_pkg::op_t       op_r, op_nxt;
  logic [13:0]        key_r, key_nxt;
  logic [23:0]        price_r, price_nxt;
  logic [19:0]        qty_r, qty_nxt;
  logic [23:0]        lo_r, lo_nxt;
  logic [23:0]        hi_r, hi_nxt;
  logic [IW-1:0]      ctr_r, ctr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               hit_r, hit_nxt;
  logic [IW-1:0]      hit_idx_r, hit_idx_nxt;
  krt_pkg::record_t   hit_rec_r, hit_rec_nxt;
  logic               pend_v_r, pend_v_nxt;
  krt_pkg::record_t   pend_rec_r, pend_rec_nxt;
  logic               out_valid_r, out_valid_nxt;
  krt_pkg::status_t   out_status_r, out_status_nxt;
  krt_pkg::record_t   out_rec_r, out_rec_nxt;
  logic               out_last_r, out_last_nxt;

  krt_pkg::cell_ctl_t ctl;
  krt_pkg::record_t   recs [CAPACITY];
  krt_pkg::record_t   nbrs [CAPACITY];
  krt_pkg::record_t   head, tail, new_rec;
  logic               accept, active, match, sel, key_ok, price_ok, qty_ok;

  assign accept   = start && !busy;
  assign busy     = (state_r != krt_pkg::S_IDLE);
  assign head     = recs[0];
  assign key_ok   = (key_r >= 14'd1) && (key_r <= krt_pkg::KEY_MAX);
  assign price_ok = (price_r <= krt_pkg::PRICE_MAX);
  assign qty_ok   = (qty_r <= krt_pkg::QTY_MAX);
  assign new_rec  = '{key: key_r, price: price_r, qty: qty_r};
  assign active   = (state_r == krt_pkg::S_SCAN) && (CW'(ctr_r) < cnt_r);
  assign match    = active && (head.key == key_r);
  assign sel      = active && ((op_r == krt_pkg::OP_LIST) ||
                    ((op_r == krt_pkg::OP_RANGE) && (head.price >= lo_r) &&
                     (head.price <= hi_r)));

  always_comb begin
    tail = head;
    if ((state_r == krt_pkg::S_SCAN) && (op_r == krt_pkg::OP_UPDATE) && match &&
        key_ok && qty_ok) begin
      tail.qty = qty_r;
    end
    if ((state_r == krt_pkg::S_SCAN) && (op_r == krt_pkg::OP_INSERT) &&
        (CW'(ctr_r) == cnt_r) && key_ok && !hit_r && price_ok && qty_ok) begin
      tail = new_rec;
    end
  end

  assign ctl.shift   = (state_r == krt_pkg::S_SCAN);
  assign ctl.compact = (state_r == krt_pkg::S_FINISH) && (op_r == krt_pkg::OP_DELETE) &&
                       hit_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      assign nbrs[i] = tail;
    end else begin : g_mid
      assign nbrs[i] = recs[i+1];
    end
    krt_cell #(
      .CAPACITY (CAPACITY),
      .POS      (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .del_idx (hit_idx_r),
      .nbr_in  (nbrs[i]),
      .rec_out (recs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    price_r      <= price_nxt;
    qty_r        <= qty_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    ctr_r        <= ctr_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_rec_r    <= hit_rec_nxt;
    pend_v_r     <= pend_v_nxt;
    pend_rec_r   <= pend_rec_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    price_nxt      = price_r;
    qty_nxt        = qty_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    ctr_nxt        = ctr_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rec_nxt    = hit_rec_r;
    pend_v_nxt     = pend_v_r;
    pend_rec_nxt   = pend_rec_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      krt_pkg::S_IDLE: begin
        if (accept && (in_opcode <= krt_pkg::OP_LIST)) begin
          op_nxt     = krt_pkg::op_t'(in_opcode);
          key_nxt    = in_key_id;
          price_nxt  = in_price_cents;
          qty_nxt    = in_new_quantity;
          lo_nxt     = in_min_price_cents;
          hi_nxt     = in_max_price_cents;
          ctr_nxt    = '0;
          hit_nxt    = 1'b0;
          pend_v_nxt = 1'b0;
          state_nxt  = krt_pkg::S_SCAN;
        end
      end
      krt_pkg::S_SCAN: begin
        if (match && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = ctr_r;
          hit_rec_nxt = tail;
        end
        if (sel) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = krt_pkg::ST_OK;
            out_rec_nxt    = pend_rec_r;
            out_last_nxt   = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_rec_nxt = head;
        end
        ctr_nxt = ctr_r + IW'(1);
        if (ctr_r == IW'(CAPACITY - 1)) begin
          state_nxt = krt_pkg::S_FINISH;
        end
      end
      krt_pkg::S_FINISH: begin
        out_valid_nxt  = 1'b1;
        out_last_nxt   = 1'b1;
        out_rec_nxt    = '0;
        out_status_nxt = krt_pkg::ST_OK;
        case (op_r)
          krt_pkg::OP_INSERT: begin
            if (!key_ok) begin
              out_status_nxt = krt_pkg::ST_KEY;
            end else if (hit_r) begin
              out_status_nxt = krt_pkg::ST_DUP;
            end else if (!price_ok) begin
              out_status_nxt = krt_pkg::ST_PRICE;
            end else if (!qty_ok) begin
              out_status_nxt = krt_pkg::ST_QTY;
            end else if (cnt_r == CW'(CAPACITY)) begin
              out_status_nxt = krt_pkg::ST_FULL;
            end else begin
              out_rec_nxt = new_rec;
              cnt_nxt     = cnt_r + CW'(1);
            end
          end
          krt_pkg::OP_UPDATE: begin
            if (!key_ok) begin
              out_status_nxt = krt_pkg::ST_KEY;
            end else if (!hit_r) begin
              out_status_nxt = krt_pkg::ST_NOT_FOUND;
            end else if (!qty_ok) begin
              out_status_nxt = krt_pkg::ST_QTY;
            end else begin
              out_rec_nxt = hit_rec_r;
            end
          end
          krt_pkg::OP_LOOKUP: begin
            if (hit_r) begin
              out_rec_nxt = hit_rec_r;
            end else begin
              out_status_nxt = krt_pkg::ST_NOT_FOUND;
            end
          end
          krt_pkg::OP_DELETE: begin
            if (hit_r) begin
              out_rec_nxt = hit_rec_r;
              cnt_nxt     = cnt_r - CW'(1);
            end else begin
              out_status_nxt = krt_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            if (pend_v_r) begin
              out_rec_nxt = pend_rec_r;
            end else begin
              out_status_nxt = krt_pkg::ST_NOMATCH;
            end
          end
        endcase
        state_nxt = krt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = krt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_id       = out_rec_r.key;
  assign out_found_price    = out_rec_r.price;
  assign out_found_quantity = out_rec_r.qty;
  assign out_last_result    = out_last_r;

  `KRT_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(CAPACITY))
  `KRT_ASSERT_IMPL(a_last_idle, out_valid && out_last_result, !busy)
  `KRT_ASSERT_IMPL(a_mid_busy, out_valid && !out_last_result, busy)
  `KRT_ASSERT_NEXT(a_start_busy, accept && (in_opcode <= krt_pkg::OP_LIST), busy)

endmodule

`default_nettype wire
